@@ design/srdm_pkg.sv @@
`default_nettype none

package srdm_pkg;

  // Ring capacity and derived widths
  localparam int QUEUE_MAX = 256;
  localparam int LOG_MAX   = $clog2(QUEUE_MAX + 1) - 1;
  localparam int IDX_W     = LOG_MAX;
  localparam int DEPTH     = 1 << IDX_W;
  localparam int LINK_W    = IDX_W + 1;
  localparam int CFG_W     = 4;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // Action codes
  localparam logic [1:0] ACT_POST = 2'd0;
  localparam logic [1:0] ACT_DONE = 2'd1;
  localparam logic [1:0] ACT_POP  = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] buf_addr;
    logic [31:0] buf_len;
    logic [15:0] buf_flags;
    logic [7:0]  done_id;
    logic [31:0] done_len;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  desc_index;
    logic [7:0]  avail_slot;
    logic [15:0] avail_count;
    logic [63:0] desc_addr;
    logic [31:0] desc_len;
    logic [15:0] desc_flags;
    logic [31:0] used_len;
    logic        used_pending;
  } res_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

  // Limit the size exponent to the largest ring that fits
  function automatic logic [CFG_W-1:0] clamp_log(input logic [CFG_W-1:0] lg);
    logic [CFG_W-1:0] r;
    r = lg;
    if (lg > CFG_W'(LOG_MAX)) begin
      r = CFG_W'(LOG_MAX);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/srdm_ctrl.sv @@
`default_nettype none

module srdm_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  output logic                      res_valid_o,
  output srdm_pkg::ctrl_cmd_t       cmd_o
);
  import srdm_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   valid_q;

  assign busy        = (state_q == ST_EXEC);
  assign res_valid_o = valid_q;
  assign cmd_o.load  = start && (state_q == ST_IDLE);
  assign cmd_o.exec  = (state_q == ST_EXEC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          valid_q <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/srdm_datapath.sv @@
`default_nettype none

module srdm_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [srdm_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  wire srdm_pkg::ctrl_cmd_t         cmd_i,
  input  wire srdm_pkg::item_t             item_i,
  output srdm_pkg::res_t                   res_o
);
  import srdm_pkg::*;

  // Control state
  logic [CFG_W-1:0]  lg_q;
  logic [LINK_W-1:0] free_head_q, free_head_d;
  logic [15:0]       avail_q, avail_d;
  logic [15:0]       used_q, used_d;
  logic [15:0]       cons_q, cons_d;
  logic [DEPTH-1:0]  link_vld_q;

  // Memories
  logic [LINK_W-1:0] link_mem [DEPTH];
  logic [7:0]        used_id_mem [DEPTH];
  logic [31:0]       used_len_mem [DEPTH];

  // Captured item and registered reads
  item_t             item_q;
  logic [LINK_W-1:0] link_rd_q;
  logic              vld_rd_q;
  logic [7:0]        used_id_rd_q;
  logic [31:0]       used_len_rd_q;
  res_t              res_q, res_d;

  // Write strobes for memories
  logic              link_we;
  logic [IDX_W-1:0]  link_wa;
  logic [LINK_W-1:0] link_wd;
  logic              used_we;
  logic [IDX_W-1:0]  used_wa;

  logic [LINK_W-1:0] n_w;
  logic [IDX_W-1:0]  mask;
  logic [IDX_W-1:0]  cons_slot;
  logic [IDX_W-1:0]  head_idx;
  logic [IDX_W-1:0]  pop_id;
  logic [IDX_W-1:0]  done_id;
  logic [LINK_W-1:0] link_val;

  assign n_w       = LINK_W'(1) << lg_q;
  assign mask      = IDX_W'(n_w - LINK_W'(1));
  assign cons_slot = cons_q[IDX_W-1:0] & mask;
  assign head_idx  = free_head_q[IDX_W-1:0];
  assign pop_id    = IDX_W'(used_id_rd_q) & mask;
  assign done_id   = IDX_W'(item_q.done_id) & mask;
  // An untouched link still holds its rebuilt value
  assign link_val  = vld_rd_q ? link_rd_q : (free_head_q + LINK_W'(1));

  always_comb begin
    free_head_d = free_head_q;
    avail_d     = avail_q;
    used_d      = used_q;
    cons_d      = cons_q;
    link_we     = 1'b0;
    link_wa     = head_idx;
    link_wd     = '0;
    used_we     = 1'b0;
    used_wa     = used_q[IDX_W-1:0] & mask;
    res_d       = '0;
    case (item_q.action)
      ACT_POST: begin
        if (free_head_q >= n_w) begin
          res_d.status = STAT_FULL;
        end else begin
          free_head_d            = link_val;
          link_we                = 1'b1;
          link_wa                = head_idx;
          link_wd                = '0;
          avail_d                = avail_q + 16'd1;
          res_d.desc_index       = 8'(head_idx);
          res_d.avail_slot       = 8'(avail_q[IDX_W-1:0] & mask);
          res_d.avail_count      = avail_d;
          res_d.desc_addr        = item_q.buf_addr;
          res_d.desc_len         = item_q.buf_len;
          res_d.desc_flags       = item_q.buf_flags;
        end
      end
      ACT_DONE: begin
        used_we          = 1'b1;
        used_d           = used_q + 16'd1;
        res_d.desc_index = 8'(done_id);
      end
      ACT_POP: begin
        if (used_q == cons_q) begin
          res_d.status = STAT_EMPTY;
        end else begin
          // Return the descriptor to the head of the free list
          link_we          = 1'b1;
          link_wa          = pop_id;
          link_wd          = free_head_q;
          free_head_d      = LINK_W'(pop_id);
          cons_d           = cons_q + 16'd1;
          res_d.desc_index = 8'(pop_id);
          res_d.used_len   = used_len_rd_q;
        end
      end
      default: begin
      end
    endcase
    res_d.used_pending = (used_d != cons_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_q        <= clamp_log(CFG_RESET);
      free_head_q <= '0;
      avail_q     <= '0;
      used_q      <= '0;
      cons_q      <= '0;
      link_vld_q  <= '0;
    end else if (cfg_we_i) begin
      lg_q        <= clamp_log(cfg_wdata_i);
      free_head_q <= '0;
      avail_q     <= '0;
      used_q      <= '0;
      cons_q      <= '0;
      link_vld_q  <= '0;
    end else if (cmd_i.exec) begin
      free_head_q <= free_head_d;
      avail_q     <= avail_d;
      used_q      <= used_d;
      cons_q      <= cons_d;
      if (link_we) begin
        link_vld_q[link_wa] <= 1'b1;
      end
    end
  end

  // Link memory: read on item capture, write during execution
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (cmd_i.load) begin
      link_rd_q <= link_mem[head_idx];
      vld_rd_q  <= link_vld_q[head_idx];
    end
  end

  // Used ring memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && used_we) begin
      used_id_mem[used_wa]  <= 8'(done_id);
      used_len_mem[used_wa] <= item_q.done_len;
    end
    if (cmd_i.load) begin
      used_id_rd_q  <= used_id_mem[cons_slot];
      used_len_rd_q <= used_len_mem[cons_slot];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (cmd_i.exec) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

@@ design/split_ring_descriptor_manager.sv @@
`default_nettype none

// Driver side of a split virtqueue with descriptor free list and used ring.
// Input channel: drive item_i and raise start; the item is taken at a rising
// edge where start is high and busy is low. Actions are post buffer, device
// completion and pop used element.
// Result channel: every item gives one result on res_o, valid for the single
// cycle in which res_valid_o is high. The receiver cannot stall it.
// Timing: an item taken at a rising edge executes in the next cycle and its
// result is shown in the cycle after that. busy is high for the execute cycle
// only, and no new item is taken while it is high, since the registered reads
// of the link and used ring memories must see the previous item's updates.
// Configuration: cfg_we_i writes queue_size_log2 from cfg_wdata_i; the user
// must do this only while the block is idle, which the block does not enforce.
// A write rebuilds the free list and clears all indices at once.
// Reset: size exponent 8, empty used ring, full free list. Per-entry valid bits
// stand in for the rebuilt links, so no clearing pass is needed after reset.
module split_ring_descriptor_manager (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [srdm_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  wire logic                        start,
  output logic                             busy,
  input  wire srdm_pkg::item_t             item_i,
  output logic                             res_valid_o,
  output srdm_pkg::res_t                   res_o
);
  import srdm_pkg::*;

  ctrl_cmd_t cmd;

  srdm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .res_valid_o (res_valid_o),
    .cmd_o       (cmd)
  );

  srdm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .item_i      (item_i),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

@@ tb/split_ring_descriptor_manager_tb.sv @@
module split_ring_descriptor_manager_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srdm_pkg::*;

  localparam logic [1:0]  ACT_UNKNOWN  = 2'd3;
  localparam logic [15:0] LINK_END     = 16'hFFFF;
  localparam int          STALL_LIMIT  = 4000;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          CFG_SETTLE   = 4;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             start       = 1'b0;
  logic             busy;
  item_t            item_i      = '0;
  logic             res_valid_o;
  res_t             res_o;

  split_ring_descriptor_manager u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Driver-side ring state mirrored in the testbench
  logic [CFG_W-1:0] drv_size_log2;
  logic [15:0]      drv_link [QUEUE_MAX];
  logic [15:0]      drv_free_head;
  logic [15:0]      drv_avail_idx;
  logic [15:0]      drv_used_idx;
  logic [15:0]      drv_consumed_idx;
  logic [7:0]       drv_used_id [QUEUE_MAX];
  logic [31:0]      drv_used_len [QUEUE_MAX];

  res_t       ring_results_q [$];
  logic [7:0] posted_ids [$];
  int         err_cnt = 0;
  int         stall_cycles = 0;
  bit         no_idle = 1'b0;

  function automatic int ring_entries();
    int lg;
    lg = int'(drv_size_log2);
    while (lg > 0 && (1 << lg) > QUEUE_MAX) lg--;
    return 1 << lg;
  endfunction

  function automatic void rebuild_free_list();
    int n;
    n = ring_entries();
    for (int i = 0; i < QUEUE_MAX; i++) drv_link[i] = 16'(i + 1);
    drv_link[n-1]    = LINK_END;
    drv_free_head    = '0;
    drv_avail_idx    = '0;
    drv_used_idx     = '0;
    drv_consumed_idx = '0;
  endfunction

  // Apply one item to the mirrored ring and return the result it produces
  function automatic res_t ring_outcome(item_t it);
    res_t        r;
    int          n;
    logic [15:0] mask;
    logic [15:0] head;
    logic [15:0] slot;
    logic [7:0]  id;
    r    = '0;
    n    = ring_entries();
    mask = 16'(n - 1);
    case (it.action)
      ACT_POST: begin
        head = drv_free_head;
        if (head >= 16'(n)) begin
          r.status = STAT_FULL;
        end else begin
          slot                  = drv_avail_idx & mask;
          drv_free_head         = drv_link[head[7:0]];
          drv_link[head[7:0]]   = '0;
          drv_avail_idx         = drv_avail_idx + 16'd1;
          r.desc_index          = head[7:0];
          r.avail_slot          = slot[7:0];
          r.avail_count         = drv_avail_idx;
          r.desc_addr           = it.buf_addr;
          r.desc_len            = it.buf_len;
          r.desc_flags          = it.buf_flags;
        end
      end
      ACT_DONE: begin
        slot                      = drv_used_idx & mask;
        id                        = it.done_id & mask[7:0];
        drv_used_id[slot[7:0]]    = id;
        drv_used_len[slot[7:0]]   = it.done_len;
        drv_used_idx              = drv_used_idx + 16'd1;
        r.desc_index              = id;
      end
      ACT_POP: begin
        if (drv_used_idx == drv_consumed_idx) begin
          r.status = STAT_EMPTY;
        end else begin
          slot             = drv_consumed_idx & mask;
          id               = drv_used_id[slot[7:0]] & mask[7:0];
          r.desc_index     = id;
          r.used_len       = drv_used_len[slot[7:0]];
          drv_consumed_idx = drv_consumed_idx + 16'd1;
          drv_link[id]     = drv_free_head;
          drv_free_head    = {8'h00, id};
        end
      end
      default: begin
      end
    endcase
    r.used_pending = (drv_used_idx != drv_consumed_idx);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && res_valid_o) begin
      if (ring_results_q.size() == 0) begin
        err_cnt++;
        $display("%0t ns: result with none outstanding, expected none actual %h",
                 $time, res_o);
      end else begin
        want = ring_results_q.pop_front();
        check_field("status", want.status, res_o.status);
        check_field("desc_index", want.desc_index, res_o.desc_index);
        check_field("avail_slot", want.avail_slot, res_o.avail_slot);
        check_field("avail_count", want.avail_count, res_o.avail_count);
        check_field("desc_addr", want.desc_addr, res_o.desc_addr);
        check_field("desc_len", want.desc_len, res_o.desc_len);
        check_field("desc_flags", want.desc_flags, res_o.desc_flags);
        check_field("used_len", want.used_len, res_o.used_len);
        check_field("used_pending", want.used_pending, res_o.used_pending);
      end
    end
  end

  // Count cycles in which neither an item nor a result moves
  always @(posedge clk_i) begin
    if (!rst_ni || (start && busy === 1'b0) || res_valid_o === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Called at a falling edge; returns at a falling edge
  task automatic send_item(input item_t it, output res_t want);
    int gap;
    item_i <= it;
    start  <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    want = ring_outcome(it);
    ring_results_q.push_back(want);
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic run_item(input logic [1:0] act, input logic [63:0] addr,
                          input logic [31:0] len, input logic [15:0] flags,
                          input logic [7:0] id, input logic [31:0] dlen);
    item_t it;
    res_t  want;
    it = '{action: act, buf_addr: addr, buf_len: len, buf_flags: flags,
           done_id: id, done_len: dlen};
    send_item(it, want);
  endtask

  task automatic wait_drained();
    while (ring_results_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_queue_size(input logic [CFG_W-1:0] lg);
    start <= 1'b0;
    wait_drained();
    repeat (CFG_SETTLE) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lg;
    drv_size_log2 = lg;
    rebuild_free_list();
    posted_ids.delete();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Full ring from reset: empty pop, unknown action, field extremes
  task automatic test_reset_state();
    run_item(ACT_POP, '0, '0, '0, '0, '0);
    run_item(ACT_UNKNOWN, '1, '1, '1, '1, '1);
    run_item(ACT_POST, '1, '1, '1, '0, '0);
    run_item(ACT_POST, '0, '0, '0, '1, '1);
    run_item(ACT_DONE, '0, '0, '0, 8'hFF, '1);
    run_item(ACT_DONE, '1, '1, '1, 8'h00, '0);
    run_item(ACT_POP, '0, '0, '0, '0, '0);
    run_item(ACT_POP, '0, '0, '0, '0, '0);
    run_item(ACT_POP, '0, '0, '0, '0, '0);
  endtask

  // Two and one entry rings: exhaustion, id masking, used ring overrun
  task automatic test_tiny_rings();
    set_queue_size(4'd1);
    run_item(ACT_POST, 64'h0123_4567_89AB_CDEF, 32'h1000, 16'h0001, '0, '0);
    run_item(ACT_POST, 64'hFEDC_BA98_7654_3210, 32'h2000, 16'h0002, '0, '0);
    run_item(ACT_POST, '1, '1, '1, '0, '0);
    run_item(ACT_DONE, '0, '0, '0, 8'hFF, 32'hDEAD_BEEF);
    run_item(ACT_DONE, '0, '0, '0, 8'h00, 32'h0000_0040);
    run_item(ACT_DONE, '0, '0, '0, 8'h01, 32'h8000_0000);
    run_item(ACT_POP, '0, '0, '0, '0, '0);
    run_item(ACT_POP, '0, '0, '0, '0, '0);
    run_item(ACT_POP, '0, '0, '0, '0, '0);
    run_item(ACT_POP, '0, '0, '0, '0, '0);
    run_item(ACT_POST, 64'h5555_5555_5555_5555, 32'h5555_5555, 16'h5555, '0, '0);
    run_item(ACT_POST, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA, 16'hAAAA, '0, '0);
    set_queue_size(4'd0);
    run_item(ACT_POST, 64'h1, 32'h1, 16'h1, '0, '0);
    run_item(ACT_POST, 64'h2, 32'h2, 16'h2, '0, '0);
    run_item(ACT_DONE, '0, '0, '0, 8'h80, 32'h0000_1234);
    run_item(ACT_POP, '0, '0, '0, '0, '0);
  endtask

  // Exponents above the ring capacity fall back to the largest ring
  task automatic test_clamped_size();
    set_queue_size(4'd15);
    run_item(ACT_POST, 64'hCAFE_0000_0000_F00D, 32'h0000_0800, 16'h0003, '0, '0);
    run_item(ACT_DONE, '0, '0, '0, 8'hAB, 32'h0000_0100);
    run_item(ACT_POP, '0, '0, '0, '0, '0);
    set_queue_size(4'd9);
    run_item(ACT_POST, 64'h0, 32'h0, 16'h0, '0, '0);
  endtask

  // Mostly driver-like traffic: completions name descriptors in flight
  task automatic test_random_traffic();
    logic [CFG_W-1:0] sizes [10] = '{4'd3, 4'd8, 4'd1, 4'd9, 4'd2,
                                    4'd0, 4'd5, 4'd15, 4'd4, 4'd8};
    item_t it;
    res_t  want;
    int    pick;
    int    k;
    foreach (sizes[p]) begin
      set_queue_size(sizes[p]);
      no_idle = (p % 4 == 1);
      repeat (64) begin
        it.buf_addr  = {$urandom, $urandom};
        it.buf_len   = $urandom;
        it.buf_flags = 16'($urandom);
        it.done_id   = 8'($urandom);
        it.done_len  = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          it.action = ACT_UNKNOWN;
        end else if (pick < 45) begin
          it.action = ACT_POST;
        end else if (pick < 75) begin
          it.action = ACT_DONE;
          if (posted_ids.size() > 0 && $urandom_range(0, 9) < 8) begin
            k = $urandom_range(0, posted_ids.size() - 1);
            it.done_id = posted_ids[k];
            posted_ids.delete(k);
          end
        end else begin
          it.action = ACT_POP;
        end
        send_item(it, want);
        if (it.action == ACT_POST && want.status == STAT_OK) begin
          posted_ids.push_back(want.desc_index);
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    drv_size_log2 = CFG_RESET;
    rebuild_free_list();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_state();
    test_tiny_rings();
    test_clamped_size();
    test_random_traffic();
    start <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && ring_results_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/srdm_pkg.sv
design/srdm_ctrl.sv
design/srdm_datapath.sv
design/split_ring_descriptor_manager.sv
tb/split_ring_descriptor_manager_tb.sv
